// File: rtl/tenf_pkg.sv
package tenf_pkg;

  // Field widths of the stream items.
  localparam int OP_W       = 2;
  localparam int SLOT_W     = 12;
  localparam int NODE_W     = 13;
  localparam int POS_FLD_W  = 4;
  localparam int TRI_W      = 3 * NODE_W;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;

  // Slot fields are 12 bits wide, so no table can be addressed beyond this span.
  localparam int SLOT_SPAN = 1 << SLOT_W;

  // Width used when comparing slots and numbers against the size parameters.
  localparam int LIM_W = 17;

  // Operation codes carried on in_tuser.
  localparam logic [OP_W-1:0] OP_WR_TRI = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_ROW = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Default sizes.
  localparam int MAX_ELEMENTS_DEF   = 4096;
  localparam int MAX_NODES_DEF      = 4096;
  localparam int NODE_ROW_WIDTH_DEF = 16;

  typedef logic [2:0][NODE_W-1:0] tri_nodes_t;

endpackage

// File: rtl/tenf_ram.sv
module tenf_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/tenf_walk.sv
module tenf_walk #(
  parameter int MAX_ELEMENTS   = 4096,
  parameter int MAX_NODES      = 4096,
  parameter int NODE_ROW_WIDTH = 16,
  parameter int TRI_AW         = 12,
  parameter int NODE_AW        = 16,
  parameter int POS_W          = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tenf_pkg::OP_W-1:0]    in_op,
  input  logic [tenf_pkg::SLOT_W-1:0]  in_element_slot,
  output logic                         tri_rd_en,
  output logic [TRI_AW-1:0]            tri_rd_addr,
  input  logic [tenf_pkg::TRI_W-1:0]   tri_rd_data,
  output logic                         row_rd_en,
  output logic [NODE_AW-1:0]           row_rd_addr,
  input  logic [tenf_pkg::NODE_W-1:0]  row_rd_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tenf_pkg::NODE_W-1:0]  out_neighbour_a,
  output logic [tenf_pkg::NODE_W-1:0]  out_neighbour_b,
  output logic [tenf_pkg::NODE_W-1:0]  out_neighbour_c
);

  import tenf_pkg::*;

  localparam logic [LIM_W-1:0]   ELEM_LIM = LIM_W'(MAX_ELEMENTS);
  localparam logic [LIM_W-1:0]   NODE_LIM = LIM_W'(MAX_NODES);
  localparam logic [NODE_W-1:0]  CNT_MAX  = NODE_W'(NODE_ROW_WIDTH - 1);
  localparam logic [POS_W-1:0]   LAST_POS = POS_W'(NODE_ROW_WIDTH - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_NODE  = 8'b0000_0100,
    S_CNT   = 8'b0000_1000,
    S_WALK  = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  tri_nodes_t          self_r, self_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    cnt_r, cnt_nxt;
  logic [NODE_AW-1:0]  base_r, base_nxt;
  logic                b_vld_r, b_vld_nxt;
  logic                c_vld_r, c_vld_nxt;
  logic [2:0][NODE_W-1:0] found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0][NODE_W-1:0] out_r, out_nxt;

  tri_nodes_t          cand_nodes;
  logic [NODE_W-1:0]   cur_node;
  logic [NODE_W-1:0]   cur_row;
  logic                node_ok;
  logic                cand_ok;
  logic [NODE_W-1:0]   cand_r, cand_nxt;
  logic [3:0]          hits;
  logic                last_node;
  logic                accept;

  assign cand_nodes = tri_rd_data;
  assign cur_node   = self_r[idx_r];
  assign cur_row    = cur_node - NODE_W'(1);
  assign node_ok    = (cur_node != '0) && (LIM_W'(cur_node) <= NODE_LIM);
  assign cand_ok    = (row_rd_data != '0) && (LIM_W'(row_rd_data) <= ELEM_LIM);
  assign last_node  = (idx_r == 2'd2);
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;

  // Shared-node count over all nine pairs; repeated node numbers count each time.
  always_comb begin
    hits = '0;
    for (int p = 0; p < 3; p++) begin
      for (int q = 0; q < 3; q++) begin
        if (self_r[p] == cand_nodes[q]) begin
          hits = hits + 4'd1;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    self_nxt      = self_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    b_vld_nxt     = 1'b0;
    c_vld_nxt     = 1'b0;
    cand_nxt      = cand_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    tri_rd_en     = 1'b0;
    tri_rd_addr   = TRI_AW'(in_element_slot);
    row_rd_en     = 1'b0;
    row_rd_addr   = base_r + NODE_AW'(pos_r);

    // Second stage: a listed element comes out of the node table.
    if (b_vld_r && cand_ok) begin
      tri_rd_en   = 1'b1;
      tri_rd_addr = TRI_AW'(row_rd_data - NODE_W'(1));
      c_vld_nxt   = 1'b1;
      cand_nxt    = row_rd_data;
    end

    // Third stage: its nodes come out of the triangle table.
    if (c_vld_r && (hits == 4'd2)) begin
      if (found_r[0] == '0) begin
        found_nxt[0] = cand_r;
      end else if (found_r[0] != cand_r) begin
        if (found_r[1] == '0) begin
          found_nxt[1] = cand_r;
        end else if (found_r[1] != cand_r) begin
          if (found_r[2] == '0) begin
            found_nxt[2] = cand_r;
          end
        end
      end
    end

    case (state_r)
      S_IDLE: begin
        found_nxt = '0;
        idx_nxt   = 2'd0;
        if (accept && (in_op == OP_QUERY)) begin
          if (LIM_W'(in_element_slot) < ELEM_LIM) begin
            tri_rd_en = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_LOAD: begin
        self_nxt  = tri_rd_data;
        state_nxt = S_NODE;
      end
      S_NODE: begin
        if (node_ok) begin
          base_nxt    = NODE_AW'(cur_row) * NODE_AW'(NODE_ROW_WIDTH);
          row_rd_en   = 1'b1;
          row_rd_addr = NODE_AW'(cur_row) * NODE_AW'(NODE_ROW_WIDTH) + NODE_AW'(LAST_POS);
          state_nxt   = S_CNT;
        end else if (last_node) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_CNT: begin
        cnt_nxt = (row_rd_data > CNT_MAX) ? LAST_POS : POS_W'(row_rd_data);
        pos_nxt = '0;
        if (row_rd_data == '0) begin
          if (last_node) begin
            state_nxt = S_DRAIN;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_NODE;
          end
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        row_rd_en = 1'b1;
        b_vld_nxt = 1'b1;
        pos_nxt   = pos_r + POS_W'(1);
        if (pos_r == cnt_r - POS_W'(1)) begin
          if (last_node) begin
            state_nxt = S_DRAIN;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_NODE;
          end
        end
      end
      S_DRAIN: begin
        if (!b_vld_r && !c_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = found_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= '0;
      idx_r       <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      b_vld_r     <= b_vld_nxt;
      c_vld_r     <= c_vld_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    self_r <= self_nxt;
    pos_r  <= pos_nxt;
    cnt_r  <= cnt_nxt;
    base_r <= base_nxt;
    cand_r <= cand_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_neighbour_a = out_r[0];
  assign out_neighbour_b = out_r[1];
  assign out_neighbour_c = out_r[2];

`ifndef NO_ASSERTIONS
  // Neighbours fill their places in order.
  a_found_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((found_r[1] == '0) || (found_r[0] != '0)) && ((found_r[2] == '0) || (found_r[1] != '0)))
    else $error("neighbour list has a gap");

  // A reported neighbour is never reported twice.
  a_found_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    ((found_r[1] == '0) || (found_r[1] != found_r[0])) &&
    ((found_r[2] == '0) || ((found_r[2] != found_r[1]) && (found_r[2] != found_r[0]))))
    else $error("neighbour reported twice");

  // The result is only formed after every lookup in flight has retired.
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (!b_vld_r && !c_vld_r))
    else $error("result formed with lookups in flight");

  // The triangle table read port has one user at a time.
  a_tri_port: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!b_vld_r && !c_vld_r))
    else $error("lookup still in flight while idle");
`endif

endmodule

// File: rtl/triangle_edge_neighbour_finder.sv
// Channel  Direction  tdata                         tuser      Handshake
// in_      slave      write or query request        operation  in_tvalid / in_tready
// out_     master     three neighbour numbers       -          out_tvalid / out_tready
//
// A write request is stored at the edge where it is accepted.
// A query reads the clamped element count of each node row and then walks that row
// through the node table's single read port, one entry per cycle; in_tready stays
// low until the query's result has moved to the output register.
// Reset clears the control state only; both tables hold nothing defined until written.
// A finished result waits in the output register; a query that finds it still
// unread holds its own result until out_tready frees the register.
module triangle_edge_neighbour_finder #(
  parameter int MAX_ELEMENTS   = tenf_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_NODES      = tenf_pkg::MAX_NODES_DEF,
  parameter int NODE_ROW_WIDTH = tenf_pkg::NODE_ROW_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // element_slot, node_a, node_b, node_c, node_slot, row_position, row_value
  input  logic [tenf_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation
  input  logic [tenf_pkg::OP_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // neighbour_a, neighbour_b, neighbour_c, one zero pad bit
  output logic [tenf_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import tenf_pkg::*;

  localparam int TRI_DEPTH = (MAX_ELEMENTS < SLOT_SPAN) ? MAX_ELEMENTS : SLOT_SPAN;
  localparam int ROW_CNT   = (MAX_NODES < SLOT_SPAN) ? MAX_NODES : SLOT_SPAN;
  localparam int TRI_AW    = (TRI_DEPTH > 1) ? $clog2(TRI_DEPTH) : 1;
  localparam int POS_W     = $clog2(NODE_ROW_WIDTH);
  localparam int ROW_DEPTH = ROW_CNT * NODE_ROW_WIDTH;
  localparam int NODE_AW   = $clog2(ROW_DEPTH);

  localparam logic [LIM_W-1:0] ELEM_LIM = LIM_W'(MAX_ELEMENTS);
  localparam logic [LIM_W-1:0] NODE_LIM = LIM_W'(MAX_NODES);
  localparam logic [LIM_W-1:0] POS_LIM  = LIM_W'(NODE_ROW_WIDTH);

  logic [SLOT_W-1:0]    element_slot;
  logic [NODE_W-1:0]    node_a, node_b, node_c;
  logic [SLOT_W-1:0]    node_slot;
  logic [POS_FLD_W-1:0] row_position;
  logic [NODE_W-1:0]    row_value;
  logic                 accept;

  logic                 tri_wr_en;
  logic                 row_wr_en;
  logic [NODE_AW-1:0]   row_wr_addr;
  logic                 tri_rd_en;
  logic [TRI_AW-1:0]    tri_rd_addr;
  logic [TRI_W-1:0]     tri_rd_data;
  logic                 row_rd_en;
  logic [NODE_AW-1:0]   row_rd_addr;
  logic [NODE_W-1:0]    row_rd_data;
  logic [NODE_W-1:0]    nb_a, nb_b, nb_c;

  assign element_slot = in_tdata[11:0];
  assign node_a       = in_tdata[24:12];
  assign node_b       = in_tdata[37:25];
  assign node_c       = in_tdata[50:38];
  assign node_slot    = in_tdata[62:51];
  assign row_position = in_tdata[66:63];
  assign row_value    = in_tdata[79:67];

  assign accept    = in_tvalid && in_tready;
  assign tri_wr_en = accept && (in_tuser == OP_WR_TRI) && (LIM_W'(element_slot) < ELEM_LIM);
  assign row_wr_en = accept && (in_tuser == OP_WR_ROW) && (LIM_W'(node_slot) < NODE_LIM) &&
                     (LIM_W'(row_position) < POS_LIM);
  assign row_wr_addr = NODE_AW'(node_slot) * NODE_AW'(NODE_ROW_WIDTH) +
                       NODE_AW'(row_position);

  tenf_ram #(
    .WIDTH (TRI_W),
    .DEPTH (TRI_DEPTH),
    .AW    (TRI_AW)
  ) u_tri_ram (
    .clk     (clk),
    .wr_en   (tri_wr_en),
    .wr_addr (TRI_AW'(element_slot)),
    .wr_data ({node_c, node_b, node_a}),
    .rd_en   (tri_rd_en),
    .rd_addr (tri_rd_addr),
    .rd_data (tri_rd_data)
  );

  tenf_ram #(
    .WIDTH (NODE_W),
    .DEPTH (ROW_DEPTH),
    .AW    (NODE_AW)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (row_wr_en),
    .wr_addr (row_wr_addr),
    .wr_data (row_value),
    .rd_en   (row_rd_en),
    .rd_addr (row_rd_addr),
    .rd_data (row_rd_data)
  );

  tenf_walk #(
    .MAX_ELEMENTS   (MAX_ELEMENTS),
    .MAX_NODES      (MAX_NODES),
    .NODE_ROW_WIDTH (NODE_ROW_WIDTH),
    .TRI_AW         (TRI_AW),
    .NODE_AW        (NODE_AW),
    .POS_W          (POS_W)
  ) u_walk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_op           (in_tuser),
    .in_element_slot (element_slot),
    .tri_rd_en       (tri_rd_en),
    .tri_rd_addr     (tri_rd_addr),
    .tri_rd_data     (tri_rd_data),
    .row_rd_en       (row_rd_en),
    .row_rd_addr     (row_rd_addr),
    .row_rd_data     (row_rd_data),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_neighbour_a (nb_a),
    .out_neighbour_b (nb_b),
    .out_neighbour_c (nb_c)
  );

  assign out_tdata = {1'b0, nb_c, nb_b, nb_a};

endmodule
